FILE: sv/cbsf_pkg.sv
// shared types, constants and function of the crc32 bit stuffed framer
// no dependencies
package cbsf_pkg;

   localparam int unsigned PAYLOAD_BYTES = 12;
   localparam int unsigned COUNT_W = 7;

   localparam logic [7:0] FLAG_VALUE = 8'h7E;
   localparam logic [2:0] RUN_LIMIT = 3'd5;
   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
   localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

   localparam int unsigned JOBQ_DEPTH = 4;
   localparam int unsigned JOBQ_AW = $clog2(JOBQ_DEPTH);
   localparam int unsigned JOBQ_CW = $clog2(JOBQ_DEPTH + 1);

   typedef enum logic [1:0] {
      JOB_DATA,
      JOB_OPEN_DATA,
      JOB_CLOSE
   } job_kind_type;

   typedef struct packed {
      job_kind_type kind;
      logic [7:0]   data;
   } job_type;

   typedef struct packed {
      logic    push;
      job_type job;
   } job_wr_type;

   typedef struct packed {
      logic    empty;
      job_type job;
   } job_rd_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] c;
      c = crc ^ {24'd0, data};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

FILE: sv/crc32_bit_stuffed_framer_top.sv
// a taken payload beat goes through the job queue and the back end bit accumulator
// to the result register; throughput is set by the back end, which either stuffs a beat
// or puts out a frame byte, and stalls output while the result register is held; the
// last beat of a frame holds the input while the crc bytes and closing flag are queued
// reset: synchronous, clears crc, counters, queue and result register
// top level of the framer; depends on cbsf_pkg, cbsf_front, cbsf_jobq, cbsf_back
module crc32_bit_stuffed_framer_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_payload_byte,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_frame_byte,
   output logic       rsp_frame_end
);

   cbsf_pkg::job_wr_type q_wr;
   cbsf_pkg::job_rd_type q_rd;
   logic                 q_full;
   logic                 q_pop;

   cbsf_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_payload_byte (req_payload_byte),
      .q_full           (q_full),
      .q_wr             (q_wr)
   );

   cbsf_jobq u_jobq (
      .clock (clock),
      .reset (reset),
      .wr    (q_wr),
      .full  (q_full),
      .pop   (q_pop),
      .rd    (q_rd)
   );

   cbsf_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_rd           (q_rd),
      .q_pop          (q_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_frame_end  (rsp_frame_end)
   );

endmodule

FILE: sv/cbsf_front.sv
// front end: takes payload beats, runs the crc and queues stuffing jobs
// depends on cbsf_pkg
module cbsf_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  logic [7:0]          req_payload_byte,
   input  logic                q_full,
   output cbsf_pkg::job_wr_type q_wr
);

   typedef enum logic [1:0] {
      ST_TAKE,
      ST_CRC,
      ST_CLOSE
   } state_type;

   state_type                     state_ff, state_in;
   logic [31:0]                   crc_ff, crc_in;
   logic [cbsf_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic [1:0]                    idx_ff, idx_in;
   logic [31:0]                   crc_out;
   logic                          accept;

   assign req_full = (state_ff != ST_TAKE) || q_full;
   assign accept   = req_push && !req_full;
   assign crc_out  = ~crc_ff;

   always_comb begin
      state_in = state_ff;
      crc_in   = crc_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      q_wr     = '0;
      q_wr.job.kind = cbsf_pkg::JOB_DATA;
      unique case (state_ff)
         ST_TAKE: begin
            q_wr.push     = accept;
            q_wr.job.data = req_payload_byte;
            q_wr.job.kind = (count_ff == '0) ? cbsf_pkg::JOB_OPEN_DATA : cbsf_pkg::JOB_DATA;
            if (accept) begin
               crc_in = cbsf_pkg::crc_byte(crc_ff, req_payload_byte);
               if (count_ff == cbsf_pkg::COUNT_W'(cbsf_pkg::PAYLOAD_BYTES - 1)) begin
                  count_in = '0;
                  idx_in   = '0;
                  state_in = ST_CRC;
               end else begin
                  count_in = count_ff + 1'b1;
               end
            end
         end
         ST_CRC: begin
            q_wr.push     = !q_full;
            q_wr.job.data = crc_out[idx_ff*8 +: 8];
            if (!q_full) begin
               idx_in = idx_ff + 1'b1;
               if (idx_ff == 2'd3) begin
                  state_in = ST_CLOSE;
               end
            end
         end
         ST_CLOSE: begin
            q_wr.push     = !q_full;
            q_wr.job.kind = cbsf_pkg::JOB_CLOSE;
            if (!q_full) begin
               crc_in   = cbsf_pkg::CRC_INIT;
               state_in = ST_TAKE;
            end
         end
         default: begin
            state_in = ST_TAKE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_TAKE;
         crc_ff   <= cbsf_pkg::CRC_INIT;
         count_ff <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         crc_ff   <= crc_in;
         count_ff <= count_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

FILE: sv/cbsf_jobq.sv
// short job queue between front and back end
// depends on cbsf_pkg
module cbsf_jobq (
   input  logic                 clock,
   input  logic                 reset,
   input  cbsf_pkg::job_wr_type wr,
   output logic                 full,
   input  logic                 pop,
   output cbsf_pkg::job_rd_type rd
);

   cbsf_pkg::job_type                mem_ff [cbsf_pkg::JOBQ_DEPTH];
   logic [cbsf_pkg::JOBQ_AW-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [cbsf_pkg::JOBQ_CW-1:0]     fill_ff;
   logic                             do_wr, do_rd;

   assign full     = (fill_ff == cbsf_pkg::JOBQ_CW'(cbsf_pkg::JOBQ_DEPTH));
   assign rd.empty = (fill_ff == '0);
   assign rd.job   = mem_ff[rd_ptr_ff];
   assign do_wr    = wr.push && !full;
   assign do_rd    = pop && !rd.empty;

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr.job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (do_wr) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_rd) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         unique case ({do_wr, do_rd})
            2'b10:   fill_ff <= fill_ff + 1'b1;
            2'b01:   fill_ff <= fill_ff - 1'b1;
            default: fill_ff <= fill_ff;
         endcase
      end
   end

endmodule

FILE: sv/cbsf_back.sv
// back end: bit stuffing, padding, flags and the result register
// depends on cbsf_pkg
module cbsf_back (
   input  logic                 clock,
   input  logic                 reset,
   input  cbsf_pkg::job_rd_type q_rd,
   output logic                 q_pop,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic [7:0]           rsp_frame_byte,
   output logic                 rsp_frame_end
);

   typedef struct packed {
      logic [9:0] bits;
      logic [3:0] n;
      logic [2:0] run;
   } stuffed_type;

   function automatic stuffed_type stuff(input logic [7:0] data, input logic [2:0] run_i);
      stuffed_type s;
      s.bits = '0;
      s.n    = '0;
      s.run  = run_i;
      for (int b = 7; b >= 0; b--) begin
         s.bits = {s.bits[8:0], data[b]};
         s.n    = s.n + 1'b1;
         s.run  = data[b] ? s.run + 1'b1 : 3'd0;
         if (s.run == cbsf_pkg::RUN_LIMIT) begin
            s.bits = {s.bits[8:0], 1'b0};
            s.n    = s.n + 1'b1;
            s.run  = '0;
         end
      end
      return s;
   endfunction

   logic [23:0] acc_ff, acc_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [2:0]  run_ff, run_in;
   logic        close_ff, close_in;
   logic        out_valid_ff, out_valid_in;
   logic [7:0]  out_byte_ff, out_byte_in;
   logic        out_end_ff, out_end_in;

   stuffed_type s;
   logic [23:0] aligned;
   logic [4:0]  pad_cnt;
   logic        slot_free;

   assign slot_free      = !out_valid_ff || rsp_pop;
   assign rsp_empty      = !out_valid_ff;
   assign rsp_frame_byte = out_byte_ff;
   assign rsp_frame_end  = out_end_ff;

   always_comb begin
      s       = stuff(q_rd.job.data, run_ff);
      aligned = {s.bits, 14'd0} << (4'd10 - s.n);
      pad_cnt = (cnt_ff == '0) ? 5'd0 : 5'd8;

      acc_in       = acc_ff;
      cnt_in       = cnt_ff;
      run_in       = run_ff;
      close_in     = close_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_byte_in  = out_byte_ff;
      out_end_in   = out_end_ff;
      q_pop        = 1'b0;

      if (cnt_ff >= 5'd8) begin
         if (slot_free) begin
            out_valid_in = 1'b1;
            out_byte_in  = acc_ff[23:16];
            out_end_in   = close_ff && (cnt_ff == 5'd8);
            acc_in       = acc_ff << 8;
            cnt_in       = cnt_ff - 5'd8;
            if (close_ff && (cnt_ff == 5'd8)) begin
               close_in = 1'b0;
            end
         end
      end else if (!q_rd.empty) begin
         q_pop = 1'b1;
         unique case (q_rd.job.kind)
            cbsf_pkg::JOB_OPEN_DATA: begin
               acc_in = {cbsf_pkg::FLAG_VALUE, 16'd0} | (aligned >> 8);
               cnt_in = 5'd8 + 5'(s.n);
               run_in = s.run;
            end
            cbsf_pkg::JOB_DATA: begin
               acc_in = acc_ff | (aligned >> cnt_ff);
               cnt_in = cnt_ff + 5'(s.n);
               run_in = s.run;
            end
            cbsf_pkg::JOB_CLOSE: begin
               acc_in   = acc_ff | ({cbsf_pkg::FLAG_VALUE, 16'd0} >> pad_cnt);
               cnt_in   = pad_cnt + 5'd8;
               run_in   = '0;
               close_in = 1'b1;
            end
            default: begin
               acc_in = acc_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         cnt_ff       <= '0;
         run_ff       <= '0;
         close_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         cnt_ff       <= cnt_in;
         run_ff       <= run_in;
         close_ff     <= close_in;
         out_valid_ff <= out_valid_in;
      end
      out_byte_ff <= out_byte_in;
      out_end_ff  <= out_end_in;
   end

endmodule

FILE: tb/tb_crc32_bit_stuffed_framer_top.sv
// self-checking testbench for crc32_bit_stuffed_framer_top: random and directed payload beats,
// a frame scoreboard that predicts every stuffed frame byte, random idling on both queues
// depends on cbsf_pkg and the framer rtl
module tb_crc32_bit_stuffed_framer_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_OFF_CYCLES = 200;
   localparam int PHASE_BEATS = 110;
   localparam logic [95:0] MIXED_PAYLOAD = 96'h00_7E_80_01_FF_FF_7F_FE_3F_F8_1F_00;

   class frame_scoreboard;
      typedef struct packed {
         logic [7:0] frame_byte;
         logic       frame_end;
      } frame_beat_type;

      logic [31:0]     crc;
      logic [2:0]      ones_run;
      logic [7:0]      bit_buf;
      logic [2:0]      bit_fill;
      logic [6:0]      byte_count;
      frame_beat_type  pending[$];
      int              mismatches;

      function new();
         mismatches = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         crc = cbsf_pkg::CRC_INIT;
         ones_run = 3'd0;
         bit_buf = 8'd0;
         bit_fill = 3'd0;
         byte_count = 7'd0;
      endfunction

      function void queue_beat(logic [7:0] value, logic last);
         frame_beat_type b;
         b.frame_byte = value;
         b.frame_end = last;
         pending.push_back(b);
      endfunction

      function void shift_bit(logic value);
         bit_buf = {bit_buf[6:0], value};
         if (bit_fill == 3'd7) begin
            queue_beat(bit_buf, 1'b0);
            bit_buf = 8'd0;
            bit_fill = 3'd0;
         end else begin
            bit_fill = bit_fill + 3'd1;
         end
      endfunction

      function void stuff_byte(logic [7:0] value);
         for (int b = 7; b >= 0; b--) begin
            shift_bit(value[b]);
            if (value[b]) begin
               ones_run = ones_run + 3'd1;
            end else begin
               ones_run = 3'd0;
            end
            if (ones_run == cbsf_pkg::RUN_LIMIT) begin
               shift_bit(1'b0);
               ones_run = 3'd0;
            end
         end
      endfunction

      function void fold_crc(logic [7:0] value);
         crc[7:0] = crc[7:0] ^ value;
         for (int k = 0; k < 8; k++) begin
            crc = crc[0] ? ((crc >> 1) ^ cbsf_pkg::CRC_POLY) : (crc >> 1);
         end
      endfunction

      function void take_payload(logic [7:0] value);
         logic [31:0] sum;
         logic [7:0]  padded;
         if (byte_count == 7'd0) begin
            queue_beat(cbsf_pkg::FLAG_VALUE, 1'b0);
         end
         fold_crc(value);
         stuff_byte(value);
         byte_count = byte_count + 7'd1;
         if (byte_count >= cbsf_pkg::PAYLOAD_BYTES) begin
            sum = ~crc;
            stuff_byte(sum[7:0]);
            stuff_byte(sum[15:8]);
            stuff_byte(sum[23:16]);
            stuff_byte(sum[31:24]);
            if (bit_fill != 3'd0) begin
               padded = bit_buf << (4'd8 - {1'b0, bit_fill});
               queue_beat(padded, 1'b0);
            end
            queue_beat(cbsf_pkg::FLAG_VALUE, 1'b1);
            clear_frame();
         end
      endfunction

      function void check_frame_byte(logic [7:0] frame_byte, logic frame_end);
         frame_beat_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected frame beat: byte %02h end %0b", frame_byte, frame_end);
            end
            return;
         end
         want = pending.pop_front();
         if (want.frame_byte !== frame_byte || want.frame_end !== frame_end) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("frame beat mismatch: expected byte %02h end %0b, got byte %02h end %0b",
                        want.frame_byte, want.frame_end, frame_byte, frame_end);
            end
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   logic       req_full;
   logic [7:0] req_payload_byte = 8'd0;
   logic       rsp_empty;
   logic       rsp_pop = 1'b0;
   logic [7:0] rsp_frame_byte;
   logic       rsp_frame_end;

   logic       pop_hold = 1'b0;
   int         send_idle_pct = 0;
   int         recv_stall_pct = 0;
   int         quiet_cycles = 0;

   frame_scoreboard board = new();

   crc32_bit_stuffed_framer_top uut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_payload_byte (req_payload_byte),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_frame_byte   (rsp_frame_byte),
      .rsp_frame_end    (rsp_frame_end)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         board.check_frame_byte(rsp_frame_byte, rsp_frame_end);
      end
      rsp_pop <= !pop_hold && ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   function automatic logic [7:0] next_payload_byte();
      logic [7:0] runs [7];
      runs = '{8'h00, 8'hFF, 8'h7E, 8'h7F, 8'hFE, 8'hF8, 8'h1F};
      case ($urandom_range(3))
         0: begin
            return runs[$urandom_range(6)];
         end
         1: begin
            return 8'($urandom) | 8'($urandom);
         end
         default: begin
            return 8'($urandom);
         end
      endcase
   endfunction

   task automatic send_payload(input logic [7:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_payload_byte <= value;
      do @(posedge clock); while (req_full);
      board.take_payload(value);
   endtask

   task automatic drain_frames();
      req_push <= 1'b0;
      do @(posedge clock); while (board.pending.size() != 0);
   endtask

   task automatic pop_hold_off();
      pop_hold <= 1'b1;
      repeat (HOLD_OFF_CYCLES) @(posedge clock);
      pop_hold <= 1'b0;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // long ones runs, then flag-like and edge bytes
      repeat (cbsf_pkg::PAYLOAD_BYTES) send_payload(8'hFF);
      for (int i = 0; i < 12; i++) begin
         send_payload(MIXED_PAYLOAD[95 - 8 * i -: 8]);
      end
      drain_frames();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
               fork
                  pop_hold_off();
               join_none
            end
            1: begin
               send_idle_pct = 65;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               recv_stall_pct = 65;
            end
            default: begin
               send_idle_pct = 37;
               recv_stall_pct = 37;
            end
         endcase
         repeat (PHASE_BEATS) send_payload(next_payload_byte());
         drain_frames();
      end

      repeat (16) @(posedge clock);
      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
